>>> sv/rgbhd_pkg.sv
package rgbhd_pkg;

    // field widths of the pixel, result and register words
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned DIST_W   = 35;
    localparam int unsigned NPIX_W   = 17;
    localparam int unsigned THR_W    = 16;
    localparam int unsigned NUM_LANE = 3;

    // threshold after reset, 0.15 in 0.16 fixed point
    localparam logic [THR_W-1:0] THR_RESET = 16'd9830;

    // per-store control from the sequencer
    typedef struct packed {
        logic inc;
        logic clr;
        logic scan_rd;
    } t_bank_ctrl;

    typedef struct packed {
        t_bank_ctrl refc;
        t_bank_ctrl winc;
    } t_lane_ctrl;

endpackage

>>> sv/rgbhd_ifc.sv
interface rgbhd_pix_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
    modport source (output valid, mode, red, green, blue, last, input ready);
    modport sink   (input valid, mode, red, green, blue, last, output ready);
endinterface

interface rgbhd_res_if;
    logic        valid;
    logic        ready;
    logic [34:0] distance_sum;
    logic [16:0] reference_pixels;
    logic        is_match;
    logic        no_reference;
    modport source (output valid, distance_sum, reference_pixels, is_match, no_reference,
                    input ready);
    modport sink   (input valid, distance_sum, reference_pixels, is_match, no_reference,
                    output ready);
endinterface

interface rgbhd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> sv/rgbhd_bank.sv
module rgbhd_bank #(
    parameter int unsigned BINS = 256,
    parameter int unsigned CW   = 17
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rgbhd_pkg::t_bank_ctrl     i_ctrl,
    input  logic [$clog2(BINS)-1:0]   i_addr,
    input  logic [$clog2(BINS)-1:0]   i_scan_addr,
    output logic [CW-1:0]             o_data
);
    import rgbhd_pkg::*;

    localparam int unsigned AW = $clog2(BINS);

    logic [CW-1:0] r_mem [BINS];
    logic [BINS-1:0] r_vld;
    logic [CW-1:0] r_rd;
    logic          r_rd_vld;
    logic [AW-1:0] rd_addr;
    logic          rd_en;

    // update stage and last-write bypass
    logic          r_s1_en;
    logic [AW-1:0] r_s1_addr;
    logic          r_s1_zero;
    logic          r_fw_en;
    logic [AW-1:0] r_fw_addr;
    logic [CW-1:0] r_fw_val;
    logic [CW-1:0] base;
    logic [CW-1:0] n_val;

    assign rd_addr = i_ctrl.inc ? i_addr : i_scan_addr;
    assign rd_en   = i_ctrl.inc | i_ctrl.scan_rd;

    // memory read and write
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd     <= r_mem[rd_addr];
            r_rd_vld <= r_vld[rd_addr];
        end
        if (r_s1_en) begin
            r_mem[r_s1_addr] <= n_val;
        end
    end

    // bin count plus one, seeing a write of the cycle before
    always_comb begin
        if (r_s1_zero) begin
            base = '0;
        end else if (r_fw_en && (r_fw_addr == r_s1_addr)) begin
            base = r_fw_val;
        end else if (r_rd_vld) begin
            base = r_rd;
        end else begin
            base = '0;
        end
        n_val = base + CW'(1);
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.inc) begin
            r_s1_addr <= i_addr;
            r_s1_zero <= i_ctrl.clr;
        end
        r_fw_addr <= r_s1_addr;
        r_fw_val  <= n_val;
    end

    // stage control and entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_en <= 1'b0;
            r_fw_en <= 1'b0;
            r_vld   <= '0;
        end else begin
            r_s1_en <= i_ctrl.inc;
            r_fw_en <= r_s1_en;
            if (r_s1_en) begin
                r_vld[r_s1_addr] <= 1'b1;
            end
            if (i_ctrl.clr) begin
                r_vld <= '0;
            end
        end
    end

    assign o_data = r_rd_vld ? r_rd : '0;

    a_clr_drops_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clr |=> (r_vld == '0) || (r_s1_en && $countones(r_vld) == 0)
        || !r_s1_en && r_vld == '0)
        else $error("clear did not empty the store");
    a_no_read_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctrl.inc && i_ctrl.scan_rd))
        else $error("scan read during pixel update");
    a_scan_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.scan_rd |-> !r_s1_en)
        else $error("scan overlaps a pending update");

endmodule

>>> sv/rgbhd_lane.sv
module rgbhd_lane #(
    parameter int unsigned BINS = 256,
    parameter int unsigned CW   = 17
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rgbhd_pkg::t_lane_ctrl     i_ctrl,
    input  logic [7:0]                i_value,
    input  logic [$clog2(BINS)-1:0]   i_scan_addr,
    output logic [2*CW-1:0]           o_sq
);
    import rgbhd_pkg::*;

    localparam int unsigned AW = $clog2(BINS);
    localparam int unsigned PW = CHAN_W + $clog2(BINS + 1);

    logic [PW-1:0] prod;
    logic [AW-1:0] bin;
    logic [CW-1:0] ref_d;
    logic [CW-1:0] win_d;
    logic [CW-1:0] diff;
    logic [2*CW-1:0] r_sq;

    // channel value to bin
    assign prod = PW'(i_value) * PW'(BINS);
    assign bin  = prod[AW+CHAN_W-1:CHAN_W];

    rgbhd_bank #(.BINS(BINS), .CW(CW)) u_ref (
        .i_clk, .i_rst_n, .i_ctrl(i_ctrl.refc), .i_addr(bin),
        .i_scan_addr, .o_data(ref_d)
    );

    rgbhd_bank #(.BINS(BINS), .CW(CW)) u_win (
        .i_clk, .i_rst_n, .i_ctrl(i_ctrl.winc), .i_addr(bin),
        .i_scan_addr, .o_data(win_d)
    );

    // squared count difference
    assign diff = (ref_d >= win_d) ? (ref_d - win_d) : (win_d - ref_d);

    always_ff @(posedge i_clk) begin
        r_sq <= (2*CW)'(diff) * (2*CW)'(diff);
    end

    assign o_sq = r_sq;

endmodule

>>> sv/rgbhd_merge.sv
module rgbhd_merge #(
    parameter int unsigned CW = 17,
    parameter int unsigned SW = 44
) (
    input  logic                  i_clk,
    input  logic                  i_clr,
    input  logic                  i_acc,
    input  logic [2*CW-1:0]       i_sq [rgbhd_pkg::NUM_LANE],
    input  logic                  i_mul_a,
    input  logic                  i_mul_b,
    input  logic [15:0]           i_thr,
    input  logic [CW-1:0]         i_n,
    output logic [SW-1:0]         o_sum,
    output logic                  o_match
);
    import rgbhd_pkg::*;

    localparam int unsigned TW = THR_W + CW;
    localparam int unsigned LW = THR_W + 2 * CW;
    localparam int unsigned MW = SW + THR_W;

    logic [SW-1:0] r_sum;
    logic [TW-1:0] r_tn;
    logic [LW-1:0] r_lim;
    logic [MW-1:0] lhs;

    // sum the lanes into the accumulator
    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_sum <= '0;
        end else if (i_acc) begin
            r_sum <= r_sum + SW'(i_sq[0]) + SW'(i_sq[1]) + SW'(i_sq[2]);
        end
    end

    // threshold times n times n, two multiply steps
    always_ff @(posedge i_clk) begin
        if (i_mul_a) begin
            r_tn <= TW'(i_thr) * TW'(i_n);
        end
        if (i_mul_b) begin
            r_lim <= LW'(r_tn) * LW'(i_n);
        end
    end

    assign lhs     = {r_sum, {THR_W{1'b0}}};
    assign o_sum   = r_sum;
    assign o_match = (i_n != '0) && (lhs < MW'(r_lim));

endmodule

>>> sv/rgbhd_top.sv
// rgb_histogram_distance_top
// throughput: one pixel per cycle; a window end stalls input through the drain,
// the bin scan that reads one address of each store per cycle in the three lanes,
// the multiply steps and the compare, which also waits for the result to be taken
// reset: synchronous active-low; stores read as empty through their valid bits at once,
// threshold returns to 0.15, the reference region is closed
module rgb_histogram_distance_top #(
    parameter int unsigned MAX_PIXELS = 65536,
    parameter int unsigned BINS       = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rgbhd_pix_if.sink     i_pix,
    rgbhd_cfg_if.sink     i_cfg,
    rgbhd_res_if.source   o_res
);
    import rgbhd_pkg::*;

    localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
    localparam int unsigned AW = $clog2(BINS);
    localparam int unsigned SW = 2 * CW + $clog2(3 * BINS);

    typedef enum logic [6:0] {
        S_RUN   = 7'b0000001,
        S_DRAIN = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_TAIL  = 7'b0001000,
        S_MULA  = 7'b0010000,
        S_MULB  = 7'b0100000,
        S_CMP   = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    logic [THR_W-1:0] r_thr;
    logic [CW-1:0] r_ref_cnt, n_ref_cnt;
    logic [CW-1:0] r_win_cnt, n_win_cnt;
    logic          r_closed, n_closed;
    logic [AW-1:0] r_scan, n_scan;
    logic          r_rd_p;
    logic          r_sq_p;
    logic          acc;
    logic [CW-1:0] ref_eff;
    logic          ref_ok;
    logic          win_ok;
    logic          load;
    t_lane_ctrl    ctrl;
    logic [7:0]    chan [NUM_LANE];
    logic [2*CW-1:0] sq [NUM_LANE];
    logic [SW-1:0] sum;
    logic          match;
    logic          r_out_vld;
    logic [DIST_W-1:0] r_dist;
    logic [NPIX_W-1:0] r_npix;
    logic          r_match;
    logic          r_noref;

    assign i_pix.ready = (r_state == S_RUN);
    assign i_cfg.ready = 1'b1;
    assign acc = i_pix.valid && i_pix.ready;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.data;
        end
    end

    // region counts and overflow guard
    assign ref_eff = r_closed ? '0 : r_ref_cnt;
    assign ref_ok  = ref_eff < CW'(MAX_PIXELS);
    assign win_ok  = r_win_cnt < CW'(MAX_PIXELS);
    assign load    = (r_state == S_CMP) && (!r_out_vld || o_res.ready);

    always_comb begin
        n_ref_cnt = r_ref_cnt;
        n_win_cnt = r_win_cnt;
        n_closed  = r_closed;
        if (acc && !i_pix.mode) begin
            n_ref_cnt = ref_ok ? ref_eff + CW'(1) : ref_eff;
            n_closed  = i_pix.last;
        end
        if (acc && i_pix.mode && win_ok) begin
            n_win_cnt = r_win_cnt + CW'(1);
        end
        if (load) begin
            n_win_cnt = '0;
        end
    end

    // store control for the lanes
    always_comb begin
        ctrl.refc.inc     = acc && !i_pix.mode && ref_ok;
        ctrl.refc.clr     = acc && !i_pix.mode && r_closed;
        ctrl.refc.scan_rd = (r_state == S_SCAN);
        ctrl.winc.inc     = acc && i_pix.mode && win_ok;
        ctrl.winc.clr     = load;
        ctrl.winc.scan_rd = (r_state == S_SCAN);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_scan  = r_scan;
        unique case (r_state)
            S_RUN: begin
                if (acc && i_pix.mode && i_pix.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_scan  = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_scan = r_scan + AW'(1);
                if (r_scan == AW'(BINS - 1)) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                if (!r_rd_p && !r_sq_p) begin
                    n_state = S_MULA;
                end
            end
            S_MULA: n_state = S_MULB;
            S_MULB: n_state = S_CMP;
            S_CMP: begin
                if (load) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_ref_cnt <= '0;
            r_win_cnt <= '0;
            r_closed  <= 1'b1;
            r_rd_p    <= 1'b0;
            r_sq_p    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ref_cnt <= n_ref_cnt;
            r_win_cnt <= n_win_cnt;
            r_closed  <= n_closed;
            r_rd_p    <= (r_state == S_SCAN);
            r_sq_p    <= r_rd_p;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
    end

    // one lane per color channel
    assign chan[0] = i_pix.red;
    assign chan[1] = i_pix.green;
    assign chan[2] = i_pix.blue;

    for (genvar g = 0; g < NUM_LANE; g++) begin : g_lane
        rgbhd_lane #(.BINS(BINS), .CW(CW)) u_lane (
            .i_clk, .i_rst_n, .i_ctrl(ctrl), .i_value(chan[g]),
            .i_scan_addr(r_scan), .o_sq(sq[g])
        );
    end

    rgbhd_merge #(.CW(CW), .SW(SW)) u_merge (
        .i_clk,
        .i_clr(r_state == S_DRAIN),
        .i_acc(r_sq_p),
        .i_sq(sq),
        .i_mul_a(r_state == S_MULA),
        .i_mul_b(r_state == S_MULB),
        .i_thr(r_thr),
        .i_n(r_ref_cnt),
        .o_sum(sum),
        .o_match(match)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dist  <= DIST_W'(sum);
            r_npix  <= NPIX_W'(r_ref_cnt);
            r_match <= match;
            r_noref <= (r_ref_cnt == '0);
        end
    end

    assign o_res.valid            = r_out_vld;
    assign o_res.distance_sum     = r_dist;
    assign o_res.reference_pixels = r_npix;
    assign o_res.is_match         = r_match;
    assign o_res.no_reference     = r_noref;

    a_window_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_pix.mode && i_pix.last) |=> (r_state == S_DRAIN))
        else $error("window end did not start the scan");
    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && r_out_vld && !o_res.ready) |=> (r_state == S_CMP))
        else $error("result overwritten before taken");
    a_ref_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ref_cnt <= CW'(MAX_PIXELS))
        else $error("reference count above limit");

endmodule

>>> sim/rgb_histogram_distance_top_test.sv
`timescale 1ns / 100ps

module rgb_histogram_distance_top_test;
    import rgbhd_pkg::*;

    localparam int unsigned BIN_CNT = 256;
    localparam int unsigned ALL_BINS = 3 * BIN_CNT;
    localparam int unsigned PIX_LIMIT = 65536;
    localparam int unsigned SCAN_WAIT = BIN_CNT + 20;
    localparam longint unsigned CYCLE_LIMIT = 2000000;

    typedef enum logic {PIX_REF = 1'b0, PIX_WIN = 1'b1} t_pix_mode;

    typedef struct packed {
        t_pix_mode mode;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic last;
    } t_pixel;

    typedef struct packed {
        logic [DIST_W-1:0] distance_sum;
        logic [NPIX_W-1:0] reference_pixels;
        logic is_match;
        logic no_reference;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    rgbhd_pix_if pix ();
    rgbhd_cfg_if cfg ();
    rgbhd_res_if res ();

    rgb_histogram_distance_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix.sink),
        .i_cfg   (cfg.sink),
        .o_res   (res.source)
    );

    // histogram predictor state
    int unsigned ref_hist [ALL_BINS];
    int unsigned win_hist [ALL_BINS];
    int unsigned ref_pixels;
    int unsigned win_pixels;
    bit ref_done;
    logic [THR_W-1:0] threshold;

    t_pixel pixel_queue [$];
    t_result expected_results [$];
    int failures;
    int results_seen;
    int matches_seen;
    int empty_ref_seen;
    longint unsigned cycle_count;

    // add one pixel to a histogram unless the region is full
    function automatic void bin_pixel(ref int unsigned hist [ALL_BINS],
                                      ref int unsigned count, input t_pixel p);
        if (count >= PIX_LIMIT)
            return;
        hist[p.red]++;
        hist[BIN_CNT + p.green]++;
        hist[2 * BIN_CNT + p.blue]++;
        count++;
    endfunction

    // update the histograms with one accepted pixel, queue a distance when a window ends
    function automatic void predict_distance(t_pixel p);
        longint unsigned sum;
        longint unsigned diff;
        longint unsigned n;
        t_result r;
        sum = 0;
        if (p.mode == PIX_REF) begin
            if (ref_done) begin
                foreach (ref_hist[i]) ref_hist[i] = 0;
                ref_pixels = 0;
                ref_done = 0;
            end
            bin_pixel(ref_hist, ref_pixels, p);
            if (p.last)
                ref_done = 1;
            return;
        end
        bin_pixel(win_hist, win_pixels, p);
        if (!p.last)
            return;
        for (int i = 0; i < ALL_BINS; i++) begin
            diff = (ref_hist[i] >= win_hist[i]) ? ref_hist[i] - win_hist[i]
                                                : win_hist[i] - ref_hist[i];
            sum += diff * diff;
        end
        n = ref_pixels;
        r.distance_sum = sum[DIST_W-1:0];
        r.reference_pixels = n[NPIX_W-1:0];
        r.no_reference = (n == 0);
        if (n == 0 || sum > (64'hFFFF_FFFF_FFFF_FFFF >> 16))
            r.is_match = 0;
        else
            r.is_match = (sum << 16) < longint'(threshold) * n * n;
        expected_results.push_back(r);
        foreach (win_hist[i]) win_hist[i] = 0;
        win_pixels = 0;
    endfunction

    function automatic t_pixel make_pixel(t_pix_mode m, int r, int g, int b, bit l);
        t_pixel p;
        p.mode = m;
        p.red = CHAN_W'(r);
        p.green = CHAN_W'(g);
        p.blue = CHAN_W'(b);
        p.last = l;
        return p;
    endfunction

    // random pixel, sometimes from a narrow palette so windows can match
    function automatic t_pixel rand_pixel(t_pix_mode m, bit l, bit narrow);
        if (narrow)
            return make_pixel(m, $urandom_range(100, 103), $urandom_range(20, 21),
                              $urandom_range(250, 255), l);
        return make_pixel(m, $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), l);
    endfunction

    // clock
    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // pixel driver
    int pix_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix.valid <= 0;
            pix_gap <= 0;
        end else if (pix.valid && !pix.ready) begin
        end else if (pix_gap > 0) begin
            pix.valid <= 0;
            pix_gap <= pix_gap - 1;
        end else if (pixel_queue.size() > 0) begin
            t_pixel p;
            p = pixel_queue.pop_front();
            pix.valid <= 1;
            pix.mode <= p.mode;
            pix.red <= p.red;
            pix.green <= p.green;
            pix.blue <= p.blue;
            pix.last <= p.last;
            pix_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 0;
        end else begin
            pix.valid <= 0;
        end
    end

    // prediction on each accepted pixel word
    always @(posedge i_clk) begin
        if (i_rst_n && pix.valid && pix.ready)
            predict_distance(make_pixel(t_pix_mode'(pix.mode), int'(pix.red),
                                        int'(pix.green), int'(pix.blue), pix.last));
    end

    // result sink with random stalls
    int res_stall;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 0;
            res_stall <= 0;
        end else if (res_stall > 0) begin
            res.ready <= 0;
            res_stall <= res_stall - 1;
        end else begin
            res.ready <= 1;
            if (res.valid && res.ready && $urandom_range(0, 2) == 0)
                res_stall <= $urandom_range(0, 5);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            t_result e;
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected");
                failures++;
            end else begin
                e = expected_results.pop_front();
                matches_seen += e.is_match;
                empty_ref_seen += e.no_reference;
                if (res.distance_sum !== e.distance_sum) begin
                    $error("distance_sum expected %0d actual %0d", e.distance_sum,
                           res.distance_sum);
                    failures++;
                end
                if (res.reference_pixels !== e.reference_pixels) begin
                    $error("reference_pixels expected %0d actual %0d",
                           e.reference_pixels, res.reference_pixels);
                    failures++;
                end
                if (res.is_match !== e.is_match) begin
                    $error("is_match expected %0d actual %0d", e.is_match, res.is_match);
                    failures++;
                end
                if (res.no_reference !== e.no_reference) begin
                    $error("no_reference expected %0d actual %0d", e.no_reference,
                           res.no_reference);
                    failures++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // wait until every queued pixel is taken and every distance has come back
    task automatic drain();
        while (pixel_queue.size() > 0 || pix.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (SCAN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        cfg.valid <= 1;
        cfg.data <= value;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        threshold = value;
        cfg.valid <= 0;
    endtask

    // one reference region then several windows of random content
    task automatic queue_scene(int ref_len, int windows);
        bit narrow;
        narrow = 1'($urandom_range(0, 1));
        for (int i = 0; i < ref_len; i++)
            pixel_queue.push_back(rand_pixel(PIX_REF, i == ref_len - 1, narrow));
        for (int w = 0; w < windows; w++) begin
            int len;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) :
                  ref_len + $urandom_range(0, 2) - 1;
            if (len < 1) len = 1;
            for (int i = 0; i < len; i++)
                pixel_queue.push_back(rand_pixel(PIX_WIN, i == len - 1,
                                                 narrow && $urandom_range(0, 7) != 0));
        end
    endtask

    initial begin
        int phase_thr [4];
        int ref_len;
        phase_thr = '{16'hFFFF, 0, 16'd30000, 16'd600};
        foreach (ref_hist[i]) begin
            ref_hist[i] = 0;
            win_hist[i] = 0;
        end
        ref_pixels = 0;
        win_pixels = 0;
        ref_done = 1;
        threshold = THR_RESET;
        failures = 0;
        results_seen = 0;
        matches_seen = 0;
        empty_ref_seen = 0;
        cycle_count = 0;
        pix.valid = 0;
        pix.mode = 0;
        pix.red = 0;
        pix.green = 0;
        pix.blue = 0;
        pix.last = 0;
        cfg.valid = 0;
        cfg.data = 0;
        res.ready = 0;
        i_rst_n = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty reference, extremes, open reference, identical windows
        pixel_queue.push_back(make_pixel(PIX_WIN, 0, 0, 0, 1));
        pixel_queue.push_back(make_pixel(PIX_WIN, 255, 255, 255, 0));
        pixel_queue.push_back(make_pixel(PIX_WIN, 170, 85, 0, 1));
        pixel_queue.push_back(make_pixel(PIX_REF, 255, 0, 255, 0));
        pixel_queue.push_back(make_pixel(PIX_REF, 0, 255, 0, 0));
        pixel_queue.push_back(make_pixel(PIX_WIN, 255, 0, 255, 1));
        pixel_queue.push_back(make_pixel(PIX_REF, 85, 170, 85, 1));
        pixel_queue.push_back(make_pixel(PIX_WIN, 255, 0, 255, 0));
        pixel_queue.push_back(make_pixel(PIX_WIN, 0, 255, 0, 0));
        pixel_queue.push_back(make_pixel(PIX_WIN, 85, 170, 85, 1));
        pixel_queue.push_back(make_pixel(PIX_WIN, 0, 0, 0, 1));
        pixel_queue.push_back(make_pixel(PIX_REF, 1, 2, 3, 1));
        pixel_queue.push_back(make_pixel(PIX_WIN, 1, 2, 3, 1));
        pixel_queue.push_back(make_pixel(PIX_WIN, 254, 253, 128, 1));
        drain();

        // random scenes under several thresholds, extremes included
        foreach (phase_thr[k]) begin
            write_threshold(THR_W'(phase_thr[k]));
            for (int s = 0; s < 7; s++) begin
                ref_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) :
                          $urandom_range(1, 10);
                queue_scene(ref_len, $urandom_range(2, 5));
                if ($urandom_range(0, 5) == 0)
                    pixel_queue.push_back(rand_pixel(t_pix_mode'($urandom_range(0, 1)),
                                                     1'($urandom_range(0, 1)), 0));
            end
            drain();
        end
        write_threshold(THR_RESET);
        for (int s = 0; s < 4; s++)
            queue_scene($urandom_range(1, 12), 3);
        drain();

        $display("covered %0d window distances, %0d matches, %0d with empty reference",
                 results_seen, matches_seen, empty_ref_seen);
        if (failures == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
